[rtl/best_fit_host_placement_defines.svh]
// Assertion macros for the best-fit host placement RTL.
`ifndef BEST_FIT_HOST_PLACEMENT_DEFINES_SVH
`define BEST_FIT_HOST_PLACEMENT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising clock edge outside reset.
`define BFHP_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define BFHP_NEVER(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`else

`define BFHP_ASSERT(name, prop, msg)
`define BFHP_NEVER(name, cond, msg)

`endif

`endif

[rtl/bfhp_pkg.sv]
// Package with sizes, codes and the cell bus types of the host placement block.
`timescale 1ns / 1ps
`default_nettype none

package bfhp_pkg;

    localparam int HOST_COUNT = 64;
    localparam int SLOT_W     = 6;
    localparam int IDX_W      = (HOST_COUNT > 1) ? $clog2(HOST_COUNT) : 1;
    localparam int ADDR_W     = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
    localparam int CPU_W      = 32;
    localparam int RAM_W      = 24;
    localparam int LABEL_W    = 16;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PLACE = 1'b1;

    // Command broadcast from the controller to every cell.
    typedef struct packed {
        logic               load;
        logic               charge;
        logic [ADDR_W-1:0]  idx;
        logic               active;
        logic [CPU_W-1:0]   cpu;
        logic [RAM_W-1:0]   ram;
        logic [LABEL_W-1:0] label;
    } t_cell_cmd;

    // Search token handed from cell to cell during a scan.
    typedef struct packed {
        logic               valid;
        logic               found;
        logic [IDX_W-1:0]   idx;
        logic [CPU_W-1:0]   slack;
        logic [LABEL_W-1:0] label;
    } t_token;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

endpackage

`default_nettype wire

[rtl/bfhp_cell.sv]
// One host slot of the chain: holds the host and updates the passing search token.
`timescale 1ns / 1ps
`default_nettype none

module bfhp_cell
    import bfhp_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [ADDR_W-1:0] i_cell_idx,
    input  wire t_cell_cmd         i_cmd,
    input  wire t_token            i_tok,
    output t_token                 o_tok
);

    logic               r_active;
    logic [CPU_W-1:0]   r_cpu;
    logic [RAM_W-1:0]   r_ram;
    logic [LABEL_W-1:0] r_label;
    t_token             r_tok;
    t_token             n_tok;

    logic               w_hit;
    logic               w_fits;
    logic               w_take;
    logic [CPU_W-1:0]   w_slack;

    assign w_hit   = (i_cmd.idx == i_cell_idx);
    assign w_fits  = r_active && (r_cpu >= i_cmd.cpu) && (r_ram >= i_cmd.ram);
    assign w_slack = r_cpu - i_cmd.cpu;
    // Strictly smaller wins, so on a tie the lower slot met first keeps the token.
    assign w_take  = i_tok.valid && w_fits && (!i_tok.found || (w_slack < i_tok.slack));

    always_comb begin
        n_tok = i_tok;
        if (w_take) begin
            n_tok.found = 1'b1;
            n_tok.idx   = i_cell_idx[IDX_W-1:0];
            n_tok.slack = w_slack;
            n_tok.label = r_label;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_tok    <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_cmd.load && w_hit) begin
                r_active <= i_cmd.active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && w_hit) begin
            r_cpu   <= i_cmd.cpu;
            r_ram   <= i_cmd.ram;
            r_label <= i_cmd.label;
        end else if (i_cmd.charge && w_hit) begin
            r_cpu <= r_cpu - i_cmd.cpu;
            r_ram <= r_ram - i_cmd.ram;
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

[rtl/best_fit_host_placement.sv]
// Top level of the best-fit host placement block: controller, cell chain and result register.
`timescale 1ns / 1ps
`default_nettype none

// Best-fit host placement. A beat with tuser low loads one host slot and leaves the
// input ready for the next beat; it gives no result. A beat with tuser high places
// one VM: a search token walks the chain of HOST_COUNT host cells, one cell per
// cycle, and each cell keeps the token's best candidate or replaces it with itself.
// The token leaving the last cell is latched into the result registers; then the
// winner is charged and the result beat is registered into the output register.
// The input accepts no beat during a placement. A finished result waits in the output
// register while new beats are taken; a placement that ends while the previous result
// is still unread waits for it. Reset marks every host inactive; no clearing pass is
// needed.
module best_fit_host_placement
    import bfhp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // slot[5:0], host_label[21:6], host_active[22], cpu_amount[54:23],
    // ram_amount[78:55], vm_label[94:79], zero pad[95]
    input  wire logic [95:0] i_s_axis_tdata,
    // operation[0]
    input  wire logic        i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // placed_vm[15:0], chosen_host[31:16]
    output logic [31:0]      o_m_axis_tdata,
    // placed[0]
    output logic             o_m_axis_tuser
);

`include "best_fit_host_placement_defines.svh"

    logic [SLOT_W-1:0]  w_slot;
    logic [LABEL_W-1:0] w_host_label;
    logic               w_host_active;
    logic [CPU_W-1:0]   w_cpu;
    logic [RAM_W-1:0]   w_ram;
    logic [LABEL_W-1:0] w_vm_label;

    assign w_slot        = i_s_axis_tdata[5:0];
    assign w_host_label  = i_s_axis_tdata[21:6];
    assign w_host_active = i_s_axis_tdata[22];
    assign w_cpu         = i_s_axis_tdata[54:23];
    assign w_ram         = i_s_axis_tdata[78:55];
    assign w_vm_label    = i_s_axis_tdata[94:79];

    t_state             r_state;
    t_state             n_state;
    logic               r_start;
    logic [CPU_W-1:0]   r_dem_cpu;
    logic [RAM_W-1:0]   r_dem_ram;
    logic [LABEL_W-1:0] r_vm;
    logic               r_res_found;
    logic [IDX_W-1:0]   r_res_idx;
    logic [LABEL_W-1:0] r_res_label;
    logic               r_out_valid;
    logic [LABEL_W-1:0] r_out_vm;
    logic [LABEL_W-1:0] r_out_host;
    logic               r_out_placed;

    logic               w_in_fire;
    logic               w_out_free;
    logic               w_emit;
    t_cell_cmd          w_cmd;
    t_token             w_tok [0:HOST_COUNT];
    t_token             w_tok_last;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_fire       = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign w_emit          = (r_state == ST_DONE) && w_out_free;
    assign w_tok_last      = w_tok[HOST_COUNT];

    always_comb begin
        w_cmd.load   = w_in_fire && (i_s_axis_tuser == OP_LOAD);
        w_cmd.charge = w_emit && r_res_found;
        w_cmd.active = w_host_active;
        w_cmd.label  = w_host_label;
        if (r_state == ST_IDLE) begin
            w_cmd.idx = ADDR_W'(w_slot);
            w_cmd.cpu = w_cpu;
            w_cmd.ram = w_ram;
        end else begin
            w_cmd.idx = ADDR_W'(r_res_idx);
            w_cmd.cpu = r_dem_cpu;
            w_cmd.ram = r_dem_ram;
        end
    end

    // The token enters the first cell in the cycle after the place beat is taken, with no candidate.
    assign w_tok[0] = '{valid: r_start, default: '0};

    for (genvar g = 0; g < HOST_COUNT; g++) begin : g_cell
        bfhp_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (ADDR_W'(g)),
            .i_cmd      (w_cmd),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire && (i_s_axis_tuser == OP_PLACE)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_tok_last.valid) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= w_in_fire && (i_s_axis_tuser == OP_PLACE);
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire && (i_s_axis_tuser == OP_PLACE)) begin
            r_dem_cpu <= w_cpu;
            r_dem_ram <= w_ram;
            r_vm      <= w_vm_label;
        end
        if ((r_state == ST_SCAN) && w_tok_last.valid) begin
            r_res_found <= w_tok_last.found;
            r_res_idx   <= w_tok_last.idx;
            r_res_label <= w_tok_last.label;
        end
        if (w_emit) begin
            r_out_vm     <= r_vm;
            r_out_host   <= r_res_found ? r_res_label : '0;
            r_out_placed <= r_res_found;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_host, r_out_vm};
    assign o_m_axis_tuser  = r_out_placed;

    `BFHP_ASSERT(a_place_starts_scan, w_in_fire && (i_s_axis_tuser == OP_PLACE) |=> r_state == ST_SCAN, "place beat did not start a scan")
    `BFHP_ASSERT(a_token_only_in_scan, w_tok_last.valid |-> r_state == ST_SCAN, "search token left the chain outside a scan")
    `BFHP_ASSERT(a_charge_needs_winner, w_cmd.charge |-> r_res_found && !w_cmd.load, "charge without a winning host")
    `BFHP_ASSERT(a_result_from_done, $rose(o_m_axis_tvalid) |-> $past(r_state) == ST_DONE, "result beat not produced by a finished scan")

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the best-fit host placement block.
`timescale 1ns / 1ps

module tb_top;
    import bfhp_pkg::*;

    typedef struct {
        bit                 drain;      // hold the sender until all placements are back
        bit                 op;
        bit [SLOT_W-1:0]    slot;
        bit [LABEL_W-1:0]   host_label;
        bit                 host_active;
        bit [CPU_W-1:0]     cpu;
        bit [RAM_W-1:0]     ram;
        bit [LABEL_W-1:0]   vm_label;
    } t_host_beat;

    typedef struct {
        bit [LABEL_W-1:0] vm;
        bit [LABEL_W-1:0] host;
        bit               placed;
    } t_placement;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic [95:0] i_s_axis_tdata = '0;
    logic        i_s_axis_tuser = 1'b0;
    logic        i_m_axis_tready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [31:0] o_m_axis_tdata;
    logic        o_m_axis_tuser;

    // Host table as the block should hold it.
    bit               host_on  [HOST_COUNT];
    bit [CPU_W-1:0]   host_cpu [HOST_COUNT];
    bit [RAM_W-1:0]   host_ram [HOST_COUNT];
    bit [LABEL_W-1:0] host_tag [HOST_COUNT];

    t_host_beat beat_q[$];
    t_placement placement_q[$];
    t_host_beat driven_beat;

    bit beat_taken;
    bit tail_phase;
    int unsigned cycle_cnt;
    int hold_gap;
    int stall_left;
    int error_cnt;
    int load_cnt, place_cnt, placed_cnt, missed_cnt;

    always #5 i_clk = ~i_clk;

    best_fit_host_placement dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH at %0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
        error_cnt++;
    endtask

    // Applies one accepted beat to the host table and queues the placement it causes.
    task automatic apply_host_beat(t_host_beat b);
        int          best;
        bit [31:0]   min_slack;
        bit [31:0]   slack;
        t_placement  res;
        if (b.op == OP_LOAD) begin
            host_on[b.slot]  = b.host_active;
            host_cpu[b.slot] = b.cpu;
            host_ram[b.slot] = b.ram;
            host_tag[b.slot] = b.host_label;
            load_cnt++;
        end else begin
            best = -1;
            min_slack = '0;
            for (int i = 0; i < HOST_COUNT; i++) begin
                if (host_on[i] && host_cpu[i] >= b.cpu && host_ram[i] >= b.ram) begin
                    slack = host_cpu[i] - b.cpu;
                    if (best < 0 || slack < min_slack) begin
                        best = i;
                        min_slack = slack;
                    end
                end
            end
            res.vm = b.vm_label;
            if (best >= 0) begin
                host_cpu[best] = host_cpu[best] - b.cpu;
                host_ram[best] = host_ram[best] - b.ram;
                res.host = host_tag[best];
                res.placed = 1'b1;
            end else begin
                res.host = '0;
                res.placed = 1'b0;
            end
            placement_q = {placement_q, res};
            place_cnt++;
        end
    endtask

    task automatic add_load(bit [5:0] slot, bit [15:0] label, bit active, bit [31:0] cpu,
                            bit [23:0] ram);
        t_host_beat b;
        b = '{default: '0};
        b.op = OP_LOAD;
        b.slot = slot;
        b.host_label = label;
        b.host_active = active;
        b.cpu = cpu;
        b.ram = ram;
        beat_q = {beat_q, b};
    endtask

    task automatic add_place(bit [15:0] vm, bit [31:0] cpu, bit [23:0] ram);
        t_host_beat b;
        b = '{default: '0};
        b.op = OP_PLACE;
        b.vm_label = vm;
        b.cpu = cpu;
        b.ram = ram;
        beat_q = {beat_q, b};
    endtask

    task automatic add_drain();
        t_host_beat b;
        b = '{default: '0};
        b.drain = 1'b1;
        beat_q = {beat_q, b};
    endtask

    // Sender: a beat stays up until taken; gaps come in bursts between beats.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_s_axis_tvalid || beat_taken) begin
                if (hold_gap > 0) begin
                    hold_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (beat_q.size() == 0) begin
                    i_s_axis_tvalid <= 1'b0;
                end else if (beat_q[0].drain) begin
                    i_s_axis_tvalid <= 1'b0;
                    if (placement_q.size() == 0)
                        void'(beat_q.pop_front());
                end else if (!tail_phase && cycle_cnt[9:8] != 2'b11 &&
                             $urandom_range(0, 7) == 0) begin
                    hold_gap = $urandom_range(0, 9);
                    i_s_axis_tvalid <= 1'b0;
                end else begin
                    driven_beat = beat_q.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tuser <= driven_beat.op;
                    i_s_axis_tdata <= {1'b0, driven_beat.vm_label, driven_beat.ram,
                                       driven_beat.cpu, driven_beat.host_active,
                                       driven_beat.host_label, driven_beat.slot};
                end
            end
            beat_taken = 1'b0;
        end
    end

    // Receiver: stalls in bursts, none in the tail of the run.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else if (!tail_phase && cycle_cnt[9:8] != 2'b10 && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 9);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Input side: every accepted beat goes through the predictor.
    always @(posedge i_clk) begin
        cycle_cnt++;
        tail_phase = beat_q.size() < 150;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            apply_host_beat(driven_beat);
            beat_taken = 1'b1;
        end
    end

    // Output side: each result beat is checked against the oldest expected placement.
    always @(posedge i_clk) begin
        t_placement want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (placement_q.size() == 0) begin
                report_mismatch("result beat with no placement pending, placed_vm",
                                32'(o_m_axis_tdata[15:0]), 32'd0);
            end else begin
                want = placement_q.pop_front();
                if (o_m_axis_tdata[15:0] !== want.vm)
                    report_mismatch("placed_vm", 32'(o_m_axis_tdata[15:0]), 32'(want.vm));
                if (o_m_axis_tdata[31:16] !== want.host)
                    report_mismatch("chosen_host", 32'(o_m_axis_tdata[31:16]),
                                    32'(want.host));
                if (o_m_axis_tuser !== want.placed)
                    report_mismatch("placed", 32'(o_m_axis_tuser), 32'(want.placed));
                if (want.placed)
                    placed_cnt++;
                else
                    missed_cnt++;
            end
        end
    end

    initial begin
        #10_000_000;
        $display("Timeout: the block stopped moving beats");
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int          random_items;
        int          n_load;
        int          n_place;
        bit [31:0]   cpu_mask;
        bit [23:0]   ram_mask;
        bit [31:0]   last_cpu;
        bit [23:0]   last_ram;
        bit [5:0]    s;

        // Directed part.
        add_place(16'h0000, 32'h0, 24'h0);                         // empty table
        add_load(6'd0, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF);
        add_load(6'd63, 16'h1234, 1'b1, 32'h0000_0100, 24'd10);
        add_load(6'd5, 16'h5555, 1'b0, 32'h0000_0010, 24'd0);      // inactive, never picked
        add_place(16'hFFFF, 32'h0, 24'h0);                         // zero demand
        add_place(16'h0001, 32'h0000_0100, 24'd10);                // exact fit
        add_place(16'h0002, 32'h0000_0100, 24'd10);
        add_load(6'd10, 16'hAAAA, 1'b1, 32'h0000_5000, 24'd100);
        add_load(6'd20, 16'h0BBB, 1'b1, 32'h0000_5000, 24'd100);
        add_place(16'h0003, 32'h0000_1000, 24'd50);                // tie goes to lower slot
        add_place(16'h0004, 32'h0000_1000, 24'd60);                // RAM rules out the best CPU
        add_load(6'd30, 16'h0000, 1'b1, 32'h0000_2000, 24'd0);     // host labeled zero
        add_place(16'h0005, 32'h0000_2000, 24'd0);
        add_place(16'h0006, 32'hFFFF_FFFF, 24'hFF_FFFF);           // no fit
        add_load(6'd0, 16'hFFFF, 1'b1, 32'hFFFF_FFFF, 24'hFF_FFFF);
        add_place(16'h0007, 32'hFFFF_FFFF, 24'hFF_FFFF);           // widest exact fit
        add_place(16'h0008, 32'h0000_0001, 24'hFF_FFFF);           // no fit on RAM alone
        add_load(6'd63, 16'h0000, 1'b0, 32'h0, 24'h0);
        add_drain();

        // Random part: rounds of host loads followed by VM placements.
        random_items = 0;
        while (random_items < 2000) begin
            case ($urandom_range(0, 3))
                0: cpu_mask = 32'h0000_00FF;
                1: cpu_mask = 32'h0000_FFFF;
                2: cpu_mask = 32'h00FF_FFFF;
                default: cpu_mask = 32'hFFFF_FFFF;
            endcase
            case ($urandom_range(0, 2))
                0: ram_mask = 24'h00_00FF;
                1: ram_mask = 24'h00_FFFF;
                default: ram_mask = 24'hFF_FFFF;
            endcase
            last_cpu = '0;
            last_ram = '0;
            if ($urandom_range(0, 19) == 0) begin
                // Take every host out of service.
                for (int i = 0; i < HOST_COUNT; i++)
                    add_load(6'(i), 16'($urandom), 1'b0, $urandom, 24'($urandom));
                random_items += HOST_COUNT;
            end
            n_load = $urandom_range(1, 16);
            for (int i = 0; i < n_load; i++) begin
                last_cpu = $urandom & cpu_mask;
                last_ram = 24'($urandom) & ram_mask;
                s = 6'($urandom_range(0, 63));
                add_load(s, 16'($urandom), $urandom_range(0, 7) != 0, last_cpu, last_ram);
            end
            n_place = $urandom_range(1, 24);
            for (int i = 0; i < n_place; i++) begin
                if ($urandom_range(0, 15) == 0) begin
                    if ($urandom_range(0, 1))
                        add_place(16'($urandom), $urandom, 24'($urandom));
                    else
                        add_load(6'($urandom), 16'($urandom), 1'($urandom), $urandom,
                                 24'($urandom));
                end else if ($urandom_range(0, 7) == 0) begin
                    add_place(16'($urandom), last_cpu, last_ram);
                end else begin
                    add_place(16'($urandom), ($urandom & cpu_mask) >> $urandom_range(0, 3),
                              24'(($urandom & 32'(ram_mask)) >> $urandom_range(0, 3)));
                end
            end
            random_items += n_load + n_place;
            if ($urandom_range(0, 7) == 0)
                add_drain();
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (beat_q.size() != 0 || i_s_axis_tvalid) @(posedge i_clk);
        while (placement_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        $display("Covered %0d host loads and %0d VM placements: %0d placed, %0d with no host.",
                 load_cnt, place_cnt, placed_cnt, missed_cnt);
        if (error_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches", error_cnt);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
